// ===== hdl/asp_pkg.sv =====
// asp_pkg: shared types and constants for the audio stream pacer.
// Used by asp_muldiv and audio_stream_pacer; depends on nothing.

package asp_pkg;

    localparam int RING_BITS = 16;
    localparam logic [16:0] RING_FRAMES = 17'd65536;
    localparam logic [11:0] CHUNK_LEN_MAX = 12'd2048;
    localparam logic [31:0] TARGET_FRAMES = 32'd4096;
    localparam logic [1:0] MAX_RESULTS = 2'd3;

    localparam logic [17:0] SRATE_RESET = 18'd44100;
    localparam logic [31:0] TRATE_RESET = 32'd1000;

    localparam logic [7:0] REG_SAMPLE_RATE = 8'd0;
    localparam logic [7:0] REG_TICK_RATE = 8'd1;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_SUBMIT = 1'b1;
    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_CHUNK = 1'b1;

    localparam int DIV_STEPS = 64;

    // request to the multiply/divide unit
    typedef struct packed {
        logic        start;
        logic [31:0] rem;      // remainder carried in, accumulator seed
        logic [63:0] diff;     // elapsed ticks
        logic [17:0] srate;    // frames per second
        logic [31:0] divisor;  // ticks per second, never zero
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } t_md_rsp;

endpackage

// ===== hdl/asp_muldiv.sv =====
// asp_muldiv: shared 65-bit adder run as shift-add multiplier, then as
// restoring divider: (rem + diff * srate) / divisor, one bit per cycle.
// Depends on asp_pkg.

module asp_muldiv
    import asp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    typedef enum logic [1:0] {P_IDLE, P_MUL, P_DIV} t_phase;

    t_phase      r_phase;
    logic [63:0] r_acc;     // product accumulator, then dividend/quotient shifter
    logic [63:0] r_mcand;
    logic [17:0] r_mplier;
    logic [31:0] r_div;
    logic [31:0] r_part;    // partial remainder
    logic [5:0]  r_cnt;
    logic        r_done;

    logic [63:0] add_a;
    logic [63:0] add_b;
    logic        add_sub;
    logic [64:0] sum;
    logic [32:0] shifted;
    logic        ge;

    assign shifted = {r_part, r_acc[63]};

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_phase)
            P_MUL: begin
                add_a = r_acc;
                add_b = r_mplier[0] ? r_mcand : 64'd0;
            end
            P_DIV: begin
                add_a   = {31'd0, shifted};
                add_b   = {32'd0, r_div};
                add_sub = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
        sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {64'd0, add_sub};
    end

    // carry out of a + ~b + 1 means a >= b
    assign ge = sum[64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_phase == P_DIV) && (r_cnt == 6'(DIV_STEPS - 1));
            unique case (r_phase)
                P_IDLE: begin
                    if (i_req.start) begin
                        r_acc    <= {32'd0, i_req.rem};
                        r_mcand  <= i_req.diff;
                        r_mplier <= i_req.srate;
                        r_div    <= i_req.divisor;
                        r_phase  <= P_MUL;
                    end
                end
                P_MUL: begin
                    if (r_mplier == 18'd0) begin
                        r_part  <= '0;
                        r_cnt   <= '0;
                        r_phase <= P_DIV;
                    end else begin
                        r_acc    <= sum[63:0];
                        r_mcand  <= {r_mcand[62:0], 1'b0};
                        r_mplier <= {1'b0, r_mplier[17:1]};
                    end
                end
                P_DIV: begin
                    r_part <= ge ? sum[31:0] : shifted[31:0];
                    r_acc  <= {r_acc[62:0], ge};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DIV_STEPS - 1)) begin
                        r_phase <= P_IDLE;
                    end
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_acc;
    assign o_rsp.rem  = r_part;

endmodule

// ===== hdl/audio_stream_pacer.sv =====
// audio_stream_pacer: top level; cursor tracking, chunk sequencer, output register.
// Depends on asp_pkg and asp_muldiv.
//
//  channel | valid       | ready       | word
//  --------+-------------+-------------+-------------------------------------------
//  input   | i_in_valid  | o_in_ready  | command, now_tick, mixer_playing, ...
//  output  | o_out_valid | i_out_ready | kind, chunk_start, chunk_len, ...
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item that advances the played cursor through time runs the multiply/divide
// unit: up to 18 multiply steps (one per sample_rate bit), a handover to the
// divider, then 64 divide steps, before a query word loads. Otherwise the cursor
// is updated in S_ADV alone. A submit passes S_CHUNK and S_EMIT per chunk word,
// S_CHUNK alone if it makes none. One item at a time; o_in_ready is high while
// the sequencer is idle, even if the last word still waits in the output register.
// A stalled output holds the sequencer.
// Reset is synchronous.

module audio_stream_pacer
    import asp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [63:0] i_now_tick,
    input  logic        i_mixer_playing,
    input  logic [31:0] i_painted_frames,
    input  logic        i_queue_ready,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [15:0] o_chunk_start,
    output logic [11:0] o_chunk_len,
    output logic [16:0] o_sample_position,
    output logic        o_last,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_ADV, S_WAIT, S_POST, S_CHUNK, S_EMIT} t_state;

    t_state      r_state;
    logic [17:0] r_srate;
    logic [31:0] r_trate;
    logic [31:0] r_p;        // played cursor
    logic [31:0] r_q;        // queued cursor
    logic [63:0] r_last_tick;
    logic [31:0] r_rem;      // remainder of the last divide, below the divisor it used

    logic        r_cmd;
    logic [63:0] r_now;
    logic        r_playing;
    logic [31:0] r_painted;
    logic        r_qready;

    logic [1:0]  r_n;
    logic [11:0] r_chunk;
    logic [31:0] r_qb;
    logic [31:0] r_avail;
    logic        r_md_start;
    logic [63:0] r_md_diff;

    logic        r_ov;
    logic        r_kind;
    logic [15:0] r_start;
    logic [11:0] r_frames;
    logic [16:0] r_spos;
    logic        r_olast;

    t_md_req     md_req;
    t_md_rsp     md_rsp;

    logic        out_free;
    logic        load_word;
    logic [31:0] buffered;
    logic        buf_le0;
    logic        clamp;
    logic [16:0] spos;
    logic [31:0] avail;
    logic        avail_pos;
    logic        below_target;
    logic [16:0] to_end;
    logic [11:0] chunk;
    logic [31:0] qb_new;
    logic [31:0] av_new;
    logic        last_nxt;

    asp_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign md_req.start   = r_md_start;
    assign md_req.rem     = r_rem;
    assign md_req.diff    = r_md_diff;
    assign md_req.srate   = r_srate;
    assign md_req.divisor = (r_trate == 32'd0) ? 32'd1 : r_trate;

    assign out_free  = !r_ov || i_out_ready;
    assign load_word = out_free && (((r_state == S_POST) && (r_cmd == CMD_QUERY))
                                    || (r_state == S_EMIT));
    assign buffered = r_q - r_p;
    assign buf_le0  = buffered[31] || (buffered == 32'd0);
    assign clamp    = (|md_rsp.quot[63:32]) || (md_rsp.quot[31:0] > buffered);
    assign spos     = {r_p[RING_BITS-1:0], 1'b0};

    assign avail        = r_painted - r_q;
    assign avail_pos    = !avail[31] && (avail != 32'd0);
    assign below_target = $signed(buffered) < $signed(TARGET_FRAMES);
    assign to_end       = RING_FRAMES - {1'b0, r_q[RING_BITS-1:0]};

    always_comb begin
        chunk = CHUNK_LEN_MAX;
        if (avail < {20'd0, CHUNK_LEN_MAX}) begin
            chunk = avail[11:0];
        end
        if (to_end < {5'd0, chunk}) begin
            chunk = to_end[11:0];
        end
    end

    // will the sequencer stop after this chunk?
    assign qb_new   = r_qb + {20'd0, r_chunk};
    assign av_new   = r_avail - {20'd0, r_chunk};
    assign last_nxt = (r_n == MAX_RESULTS - 2'd1)
                   || !($signed(qb_new) < $signed(TARGET_FRAMES))
                   || av_new[31] || (av_new == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_srate     <= SRATE_RESET;
            r_trate     <= TRATE_RESET;
            r_p         <= '0;
            r_q         <= '0;
            r_last_tick <= '0;
            r_rem       <= '0;
            r_n         <= '0;
            r_ov        <= 1'b0;
            r_md_start  <= 1'b0;
        end else begin
            r_md_start <= (r_state == S_ADV) && !buf_le0 && r_playing;
            if (load_word) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_SAMPLE_RATE: r_srate <= i_cfg_data[17:0];
                    REG_TICK_RATE:   r_trate <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= i_command;
                        r_now     <= i_now_tick;
                        r_playing <= i_mixer_playing;
                        r_painted <= i_painted_frames;
                        r_qready  <= i_queue_ready;
                        r_state   <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_last_tick <= r_now;
                    if (buf_le0 || !r_playing) begin
                        r_p     <= r_q;
                        r_rem   <= '0;
                        r_state <= S_POST;
                    end else begin
                        // a zero last tick means not started: no time has passed
                        r_md_diff  <= (r_last_tick == 64'd0) ? 64'd0 : r_now - r_last_tick;
                        r_state    <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (md_rsp.done) begin
                        if (clamp) begin
                            r_p   <= r_q;
                            r_rem <= '0;
                        end else begin
                            r_p   <= r_p + md_rsp.quot[31:0];
                            r_rem <= md_rsp.rem;
                        end
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_cmd == CMD_QUERY) begin
                        if (out_free) begin
                            r_kind   <= KIND_POSITION;
                            r_start  <= '0;
                            r_frames <= '0;
                            r_spos   <= spos;
                            r_olast  <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        if (buffered[31]) begin
                            r_q <= r_p;
                        end
                        r_n     <= '0;
                        r_state <= S_CHUNK;
                    end
                end
                S_CHUNK: begin
                    if (below_target && avail_pos && r_qready && r_n != MAX_RESULTS) begin
                        r_chunk <= chunk;
                        r_qb    <= buffered;
                        r_avail <= avail;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_kind   <= KIND_CHUNK;
                        r_start  <= r_q[RING_BITS-1:0];
                        r_frames <= r_chunk;
                        r_spos   <= spos;
                        r_olast  <= last_nxt;
                        r_q      <= r_q + {20'd0, r_chunk};
                        r_n      <= r_n + 2'd1;
                        if (r_last_tick == 64'd0) begin
                            r_rem <= '0;
                        end
                        r_state  <= last_nxt ? S_IDLE : S_CHUNK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_ov;
    assign o_kind            = r_kind;
    assign o_chunk_start     = r_start;
    assign o_chunk_len       = r_frames;
    assign o_sample_position = r_spos;
    assign o_last            = r_olast;

endmodule

// ===== sim/audio_stream_pacer_tb.sv =====
// audio_stream_pacer_tb: self-checking testbench for the audio stream pacer.
// Drives items and register writes, predicts every output word, compares in order.
// Depends on asp_pkg and audio_stream_pacer.

module audio_stream_pacer_tb;
    import asp_pkg::*;

    localparam int DRAIN_CYCLES = 200;     // covers the multiply/divide pass plus chunk steps
    localparam int HOLD_CYCLES = 300;
    localparam logic [7:0] REG_UNUSED_LO = 8'd2;
    localparam logic [7:0] REG_UNUSED_HI = 8'hFF;

    typedef struct {
        logic        kind;
        logic [15:0] start;
        logic [11:0] frames;
        logic [16:0] spos;
        logic        last;
    } t_pacer_word;

    logic        i_clk;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_cmd = CMD_QUERY;
    logic [63:0] in_tick = '0;
    logic        in_playing = 1'b0;
    logic [31:0] in_painted = '0;
    logic        in_qready = 1'b0;
    logic        o_in_ready;

    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic        o_kind;
    logic [15:0] o_chunk_start;
    logic [11:0] o_chunk_len;
    logic [16:0] o_sample_position;
    logic        o_last;

    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        o_cfg_ready;

    // predictor copy of the block's state and registers
    logic [31:0] played_cur = '0;
    logic [31:0] queued_cur = '0;
    logic [63:0] tick_mark = '0;
    logic [63:0] frac_rem = '0;
    logic [17:0] cfg_srate = SRATE_RESET;
    logic [31:0] cfg_trate = TRATE_RESET;

    t_pacer_word due_words[$];
    int fails = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    audio_stream_pacer dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (in_cmd),
        .i_now_tick        (in_tick),
        .i_mixer_playing   (in_playing),
        .i_painted_frames  (in_painted),
        .i_queue_ready     (in_qready),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_kind            (o_kind),
        .o_chunk_start     (o_chunk_start),
        .o_chunk_len       (o_chunk_len),
        .o_sample_position (o_sample_position),
        .o_last            (o_last),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** audio_stream_pacer: FAILED **");
        $finish;
    end

    // advance the played cursor from elapsed time, then queue the words this item causes
    task automatic pace_item(input logic cmd, input logic [63:0] now, input logic playing,
                             input logic [31:0] painted, input logic qready);
        int buffered;
        int avail;
        int n;
        logic [63:0] div;
        logic [63:0] elapsed;
        logic [31:0] chunk;
        logic [31:0] to_end;
        logic [15:0] start;
        logic [16:0] spos;
        t_pacer_word w;
        buffered = $signed(queued_cur - played_cur);
        if (buffered < 0) begin
            played_cur = queued_cur;
            buffered = 0;
            frac_rem = '0;
        end
        if (tick_mark == 64'd0)
            tick_mark = now;
        if (buffered == 0 || !playing) begin
            played_cur = queued_cur;
            tick_mark = now;
            frac_rem = '0;
        end else begin
            frac_rem = frac_rem + (now - tick_mark) * {46'd0, cfg_srate};
            tick_mark = now;
            div = (cfg_trate == 32'd0) ? 64'd1 : {32'd0, cfg_trate};
            elapsed = frac_rem / div;
            frac_rem = frac_rem % div;
            if (elapsed > {32'd0, buffered}) begin
                elapsed = {32'd0, buffered};
                frac_rem = '0;
            end
            played_cur = played_cur + elapsed[31:0];
        end
        spos = {played_cur[15:0], 1'b0};

        if (cmd == CMD_QUERY) begin
            w.kind = KIND_POSITION;
            w.start = '0;
            w.frames = '0;
            w.spos = spos;
            w.last = 1'b1;
            due_words.push_back(w);
        end else begin
            if ($signed(queued_cur - played_cur) < 0)
                queued_cur = played_cur;
            n = 0;
            while (n < int'(MAX_RESULTS)) begin
                buffered = $signed(queued_cur - played_cur);
                if (buffered >= int'(TARGET_FRAMES))
                    break;
                avail = $signed(painted - queued_cur);
                if (avail <= 0)
                    break;
                chunk = 32'(CHUNK_LEN_MAX);
                if (chunk > avail)
                    chunk = avail;
                start = queued_cur[15:0];
                to_end = 32'(RING_FRAMES) - {16'd0, start};
                if (chunk > to_end)
                    chunk = to_end;
                if (chunk == 32'd0 || !qready)
                    break;
                w.kind = KIND_CHUNK;
                w.start = start;
                w.frames = chunk[11:0];
                w.spos = spos;
                w.last = 1'b0;
                due_words.push_back(w);
                n++;
                queued_cur = queued_cur + chunk;
                if (tick_mark == 64'd0) begin
                    tick_mark = now;
                    frac_rem = '0;
                end
            end
            if (n > 0) begin
                w = due_words.pop_back();
                w.last = 1'b1;
                due_words.push_back(w);
            end
        end
    endtask

    // called at a rising edge; returns at the edge where the word was taken
    task automatic send_item(input logic cmd, input logic [63:0] tick, input logic playing,
                             input logic [31:0] painted, input logic qready);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_cmd <= cmd;
        in_tick <= tick;
        in_playing <= playing;
        in_painted <= painted;
        in_qready <= qready;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pace_item(cmd, tick, playing, painted, qready);
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (due_words.size() != 0);
    endtask

    // a submit may leave no word behind, so give the block time to finish after the last one
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == REG_SAMPLE_RATE)
            cfg_srate = data[17:0];
        else if (idx == REG_TICK_RATE)
            cfg_trate = data;
    endtask

    task automatic test_directed_basics;
        logic [63:0] t;
        send_idle = 19;
        recv_idle = 69;
        send_item(CMD_QUERY, 64'd0, 1'b0, 32'd0, 1'b0);               // not started yet
        send_item(CMD_SUBMIT, 64'd0, 1'b1, 32'd0, 1'b1);              // nothing painted
        send_item(CMD_SUBMIT, 64'd0, 1'b1, 32'hFFFF_FFFF, 1'b1);      // painted behind queued
        send_item(CMD_SUBMIT, 64'd0, 1'b1, 32'd3000, 1'b0);           // mixer refuses
        send_item(CMD_SUBMIT, 64'd0, 1'b1, 32'd3000, 1'b1);           // chunks before first tick
        send_item(CMD_QUERY, 64'd20, 1'b1, 32'd3000, 1'b0);
        send_item(CMD_QUERY, 64'd30, 1'b1, 32'd3000, 1'b1);
        send_item(CMD_SUBMIT, 64'd40, 1'b0, 32'h7FFF_FFFF, 1'b1);     // mixer idle, catch up
        send_item(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd0, 1'b0);
        send_item(CMD_QUERY, 64'd5, 1'b1, 32'd0, 1'b1);               // time runs backward
        t = 64'd6;
        repeat (14) begin
            send_item(CMD_SUBMIT, t, 1'b0, queued_cur + 32'd4096, 1'b1);
            t = t + 64'd1;
        end
        // next submit runs into the ring end and wraps to frame zero
        send_item(CMD_SUBMIT, t, 1'b0, queued_cur + 32'd6000, 1'b1);
    endtask

    task automatic test_register_edges;
        write_reg(REG_UNUSED_LO, 32'd12345);
        write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
        send_item(CMD_SUBMIT, tick_mark + 64'd10, 1'b1, queued_cur + 32'd2500, 1'b1);
        send_item(CMD_QUERY, tick_mark + 64'd10, 1'b1, 32'd0, 1'b0);
        write_reg(REG_TICK_RATE, 32'd0);                               // divides as one
        write_reg(REG_SAMPLE_RATE, 32'd192000);
        send_item(CMD_SUBMIT, tick_mark, 1'b1, queued_cur + 32'd4000, 1'b1);
        send_item(CMD_QUERY, tick_mark + 64'd1, 1'b1, 32'd0, 1'b1);
        send_item(CMD_SUBMIT, tick_mark, 1'b1, queued_cur + 32'd4000, 1'b1);
        send_item(CMD_QUERY, tick_mark, 1'b1, 32'd0, 1'b0);
    endtask

    // mostly well-formed traffic steered from the predicted cursors, some raw noise
    task automatic test_random_traffic(input int count);
        logic cmd;
        logic playing;
        logic qready;
        logic [63:0] tick;
        logic [63:0] span;
        logic [63:0] r;
        logic [31:0] painted;
        logic [31:0] tr;
        logic [17:0] sr;
        for (int k = 0; k < count; k++) begin
            tr = (cfg_trate == 32'd0) ? 32'd1 : cfg_trate;
            sr = (cfg_srate == 18'd0) ? 18'd1 : cfg_srate;
            span = (64'd3000 * {32'd0, tr}) / {46'd0, sr};
            r = {$urandom, $urandom};
            if ($urandom_range(99) < 12) begin
                cmd = $urandom_range(1);
                tick = {$urandom, $urandom};
                playing = $urandom_range(1);
                painted = $urandom;
                qready = $urandom_range(1);
            end else begin
                cmd = ($urandom_range(99) < 55) ? CMD_SUBMIT : CMD_QUERY;
                tick = tick_mark + r % (span + 64'd1);
                playing = $urandom_range(99) < 90;
                painted = queued_cur + $urandom_range(6000);
                qready = $urandom_range(99) < 88;
            end
            send_item(cmd, tick, playing, painted, qready);
        end
    endtask

    task automatic test_output_backpressure;
        send_idle = 0;
        recv_idle = 0;
        hold_seq <= hold_seq + 1;
        for (int k = 0; k < 15; k++)
            send_item((k % 2) ? CMD_QUERY : CMD_SUBMIT, tick_mark + $urandom_range(3000),
                      1'b1, queued_cur + 32'd5000, 1'b1);
        wait_drained();
        repeat (3)
            send_item(CMD_SUBMIT, tick_mark + $urandom_range(3000), 1'b1,
                      queued_cur + $urandom_range(5000), 1'b1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_register_edges();

        write_reg(REG_SAMPLE_RATE, 32'd44100);
        write_reg(REG_TICK_RATE, 32'd1000);
        send_idle = 19;
        recv_idle = 69;
        test_random_traffic(100);

        write_reg(REG_SAMPLE_RATE, 32'd192000);
        write_reg(REG_TICK_RATE, 32'hFFFF_FFFF);
        send_idle = 69;
        recv_idle = 19;
        test_random_traffic(100);

        write_reg(REG_SAMPLE_RATE, 32'd1);
        write_reg(REG_TICK_RATE, 32'd1);
        test_output_backpressure();
        test_random_traffic(50);

        write_reg(REG_SAMPLE_RATE, 32'd48000);
        write_reg(REG_TICK_RATE, 32'd0);
        send_idle = 0;
        recv_idle = 0;
        test_random_traffic(50);

        // words still owed at the end never arrive and run into the time limit
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0)
            $display("** audio_stream_pacer: PASSED **");
        else
            $display("** audio_stream_pacer: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        fails++;
    endtask

    always @(posedge i_clk) begin : check_words
        t_pacer_word w;
        if (rst_n && o_out_valid && out_ready) begin
            if (due_words.size() == 0) begin
                $display("%0t: unexpected word, expected none actual kind %0d start %0d",
                         $time, o_kind, o_chunk_start);
                fails++;
            end else begin
                w = due_words.pop_front();
                if (o_kind !== w.kind)
                    report_field("kind", w.kind, o_kind);
                if (o_chunk_start !== w.start)
                    report_field("chunk_start", w.start, o_chunk_start);
                if (o_chunk_len !== w.frames)
                    report_field("chunk_len", w.frames, o_chunk_len);
                if (o_sample_position !== w.spos)
                    report_field("sample_position", w.spos, o_sample_position);
                if (o_last !== w.last)
                    report_field("last", w.last, o_last);
            end
        end
    end

endmodule
